// ----- design/assert_macros.svh -----
// Assertion macros shared by the primitive assembler RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset
`define PA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen outside reset
`define PA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PA_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- design/pa_pkg.sv -----
// Shared types and codes for the primitive assembler.
// No dependencies; used by pa_index_unit and primitive_assembler_core.
package pa_pkg;

    localparam int IDX_W   = 32;
    localparam int TYPE_W  = 3;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Primitive type codes
    localparam logic [TYPE_W-1:0] PT_POINTS    = 3'd0;
    localparam logic [TYPE_W-1:0] PT_LINE_LIST = 3'd1;
    localparam logic [TYPE_W-1:0] PT_LINE_STRIP = 3'd2;
    localparam logic [TYPE_W-1:0] PT_TRI_LIST  = 3'd3;
    localparam logic [TYPE_W-1:0] PT_TRI_STRIP = 3'd4;
    localparam logic [TYPE_W-1:0] PT_TRI_FAN   = 3'd5;

    // Primitive kind codes
    localparam logic [KIND_W-1:0] PK_POINT = 2'd0;
    localparam logic [KIND_W-1:0] PK_LINE  = 2'd1;
    localparam logic [KIND_W-1:0] PK_TRI   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRIM_TYPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_LIMIT = 2'd2;

    // One processed index: element number and its flags
    typedef struct packed {
        logic [IDX_W-1:0] elem;
        logic             clamped;
        logic             skip;
    } idx_info_t;

endpackage

// ----- design/pa_index_unit.sv -----
// Index clamp and base offset for the primitive assembler.
// Depends on pa_pkg; instanced by primitive_assembler_core.
module pa_index_unit (
    input  logic [pa_pkg::IDX_W-1:0]  vertex_index,
    input  logic [pa_pkg::TYPE_W-1:0] prim_type,
    input  logic [pa_pkg::IDX_W-1:0]  vertex_base,
    input  logic [pa_pkg::IDX_W-1:0]  vertex_limit,
    output pa_pkg::idx_info_t         info
);
    import pa_pkg::*;

    logic over_limit;

    // Out-of-range indices fold to zero before the offset
    assign over_limit   = (vertex_index >= vertex_limit);
    assign info.clamped = over_limit;
    assign info.elem    = (over_limit ? '0 : vertex_index) + vertex_base;

    // Word is dropped for an empty vertex range or an unknown type
    assign info.skip    = (vertex_limit == '0) || (prim_type > PT_TRI_FAN);

endmodule

// ----- design/primitive_assembler_core.sv -----
// Primitive assembler top level: index register, assembly logic, result register.
// Depends on pa_pkg, pa_index_unit and assert_macros.svh.
//
//  channel | dir | handshake        | payload
//  s_*     | in  | s_tvalid/tready  | tdata: vertex_index; tuser: first
//  m_*     | out | m_tvalid/tready  | tdata: prim_number,a,b,c; tuser: kind,clamped
//  cfg_*   | in  | cfg_write        | cfg_index, cfg_data
//
// One index word per cycle sustained unless an output stall holds a word that makes a result;
// a result's last index passes through the index register, then the result register.
// rst_n clears the stage valids, the held indices, counter, vertex base and limit; the type resets to triangle list.
// A stall on m_tready holds the result register and reaches s_tready in the
// same cycle only when the registered index would produce a result.
`include "assert_macros.svh"
module primitive_assembler_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // index stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [31:0] vertex_index
    input  logic [0:0]                   s_tuser,   // [0] first
    // primitive stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [127:0]                 m_tdata,   // prim_number, vertex_a, vertex_b, vertex_c
    output logic [2:0]                   m_tuser,   // [1:0] prim_kind, [2] index_clamped
    // configuration
    input  logic                         cfg_write,
    input  logic [pa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data
);
    import pa_pkg::*;

    // configuration registers
    logic [TYPE_W-1:0] prim_type_reg;
    logic [IDX_W-1:0]  vertex_base_reg;
    logic [IDX_W-1:0]  vertex_limit_reg;

    // index stage
    idx_info_t         idx_info;
    logic              s1_valid_reg;
    idx_info_t         s1_info_reg;
    logic              s1_first_reg;
    logic              s1_adv;

    // batch state
    logic [IDX_W-1:0]  hf_reg, hf_next;
    logic [IDX_W-1:0]  hs_reg, hs_next;
    logic              hfc_reg, hfc_next;
    logic              hsc_reg, hsc_next;
    logic [1:0]        seen_reg, seen_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;

    // result register
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_num_reg, out_a_reg, out_b_reg, out_c_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic              out_clamp_reg;
    logic              out_free;

    // assembled result of the registered word
    logic              emit;
    logic [KIND_W-1:0] res_kind;
    logic [IDX_W-1:0]  res_a, res_b, res_c;
    logic              res_clamp;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_type_reg    <= PT_TRI_LIST;
            vertex_base_reg  <= '0;
            vertex_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PRIM_TYPE:    prim_type_reg    <= cfg_data[TYPE_W-1:0];
                CFG_VERTEX_BASE:  vertex_base_reg  <= cfg_data;
                CFG_VERTEX_LIMIT: vertex_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    pa_index_unit u_index (
        .vertex_index (s_tdata),
        .prim_type    (prim_type_reg),
        .vertex_base  (vertex_base_reg),
        .vertex_limit (vertex_limit_reg),
        .info         (idx_info)
    );

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && (!emit || out_free);
    assign s_tready = !s1_valid_reg || s1_adv;

    // index register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_info_reg  <= idx_info;
            s1_first_reg <= s_tuser[0];
        end
    end

    // assembly: held state after an optional batch restart, then type rules
    always_comb
    begin
        logic [IDX_W-1:0] hf, hs, cnt, v;
        logic             hfc, hsc, c;
        logic [1:0]       seen;

        hf   = s1_first_reg ? '0 : hf_reg;
        hs   = s1_first_reg ? '0 : hs_reg;
        hfc  = s1_first_reg ? 1'b0 : hfc_reg;
        hsc  = s1_first_reg ? 1'b0 : hsc_reg;
        seen = s1_first_reg ? 2'd0 : seen_reg;
        cnt  = s1_first_reg ? '0 : cnt_reg;
        v    = s1_info_reg.elem;
        c    = s1_info_reg.clamped;

        hf_next   = hf;
        hs_next   = hs;
        hfc_next  = hfc;
        hsc_next  = hsc;
        seen_next = seen;
        emit      = 1'b0;
        res_kind  = PK_TRI;
        res_a     = hf;
        res_b     = hs;
        res_c     = v;
        res_clamp = hfc | hsc | c;

        if (!s1_info_reg.skip)
        begin
            case (prim_type_reg)
                PT_POINTS:
                begin
                    emit      = 1'b1;
                    res_kind  = PK_POINT;
                    res_a     = v;
                    res_b     = '0;
                    res_c     = '0;
                    res_clamp = c;
                end
                PT_LINE_LIST, PT_LINE_STRIP:
                begin
                    if (seen == 2'd0)
                    begin
                        hf_next   = v;
                        hfc_next  = c;
                        seen_next = 2'd1;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        res_kind  = PK_LINE;
                        res_a     = hf;
                        res_b     = v;
                        res_c     = '0;
                        res_clamp = hfc | c;
                        if (prim_type_reg == PT_LINE_LIST)
                            seen_next = 2'd0;
                        else
                        begin
                            hf_next   = v;
                            hfc_next  = c;
                            seen_next = 2'd1;
                        end
                    end
                end
                default:
                begin
                    // triangle list, strip and fan
                    if (seen == 2'd0)
                    begin
                        hf_next   = v;
                        hfc_next  = c;
                        seen_next = 2'd1;
                    end
                    else if (seen == 2'd1)
                    begin
                        hs_next   = v;
                        hsc_next  = c;
                        seen_next = 2'd2;
                    end
                    else
                    begin
                        emit = 1'b1;
                        if (prim_type_reg == PT_TRI_LIST)
                            seen_next = 2'd0;
                        else if (prim_type_reg == PT_TRI_STRIP)
                        begin
                            hf_next   = hs;
                            hfc_next  = hsc;
                            hs_next   = v;
                            hsc_next  = c;
                            seen_next = 2'd2;
                            // odd strip triangles swap their last two corners
                            if (cnt[0])
                            begin
                                res_b = v;
                                res_c = hs;
                            end
                        end
                        else
                        begin
                            hs_next   = v;
                            hsc_next  = c;
                            seen_next = 2'd2;
                        end
                    end
                end
            endcase
        end

        cnt_next = emit ? cnt + 1'b1 : cnt;
    end

    // batch state update when the registered word moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_reg   <= '0;
            hs_reg   <= '0;
            hfc_reg  <= 1'b0;
            hsc_reg  <= 1'b0;
            seen_reg <= 2'd0;
            cnt_reg  <= '0;
        end
        else if (s1_adv)
        begin
            hf_reg   <= hf_next;
            hs_reg   <= hs_next;
            hfc_reg  <= hfc_next;
            hsc_reg  <= hsc_next;
            seen_reg <= seen_next;
            cnt_reg  <= cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            out_num_reg   <= s1_first_reg ? '0 : cnt_reg;
            out_kind_reg  <= res_kind;
            out_a_reg     <= res_a;
            out_b_reg     <= res_b;
            out_c_reg     <= res_c;
            out_clamp_reg <= res_clamp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_c_reg, out_b_reg, out_a_reg, out_num_reg};
    assign m_tuser  = {out_clamp_reg, out_kind_reg};

    // checks
    `PA_NEVER(a_seen_range, clk, rst_n, seen_reg == 2'd3, "held index count out of range")
    `PA_ASSERT(a_cnt_step, clk, rst_n, (s1_adv && emit && !s1_first_reg) |=> (cnt_reg == $past(cnt_reg) + 1'b1), "primitive counter did not step")
    `PA_ASSERT(a_point_shape, clk, rst_n, (m_tvalid && m_tuser[1:0] == PK_POINT) |-> (m_tdata[127:64] == '0), "point carries extra corners")
    `PA_ASSERT(a_stall_cause, clk, rst_n, (s1_valid_reg && !s1_adv) |-> (out_valid_reg && !m_tready), "index stage stalled without output back-pressure")

endmodule
